FILE: rtl/core/bmfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap find-first package
// Operation codes, field widths and default sizes shared by the bitmap unit.
// ---------------------------------------------------------------------------
package bmfs_pkg;

  localparam int BIT_COUNT_DEF = 1024;
  localparam int WORD_BITS_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int BITNUM_W = 10;
  localparam int INDEX_W  = 10;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET_BIT    = 3'd0,
    FN_CLEAR_BIT  = 3'd1,
    FN_FIND_SET   = 3'd2,
    FN_FIND_CLEAR = 3'd3,
    FN_FILL_ONES  = 3'd4,
    FN_CLEAR_ALL  = 3'd5
  } func_t;

  // Status of the word currently on the shared word unit.
  typedef struct packed {
    logic hit;
    logic old_zero;
    logic old_full;
    logic new_zero;
    logic new_full;
  } word_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/bmfs_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap word store
// Single write port, single read port, read data registered.
// ---------------------------------------------------------------------------
module bmfs_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/bmfs_word_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap word unit
// Shared per-word logic: lowest matching bit search, single-bit update and
// zero/full detection of the word before and after the update.
// ---------------------------------------------------------------------------
module bmfs_word_unit
  import bmfs_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int BW        = 6
) (
  input  wire logic [WORD_BITS-1:0] word,
  input  wire logic                 find_clear,
  input  wire logic                 op_set,
  input  wire logic [BW-1:0]        bit_pos,
  output logic      [BW-1:0]        hit_pos,
  output logic      [WORD_BITS-1:0] new_word,
  output word_stat_t                stat
);

  logic [WORD_BITS-1:0] match;
  logic [WORD_BITS-1:0] bit_mask;

  always_comb begin
    match   = find_clear ? ~word : word;
    hit_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_pos = BW'(i);
      end
    end
  end

  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_pos;
  assign new_word = op_set ? (word | bit_mask) : (word & ~bit_mask);

  assign stat.hit      = |match;
  assign stat.old_zero = ~|word;
  assign stat.old_full = &word;
  assign stat.new_zero = ~|new_word;
  assign stat.new_full = &new_word;

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_find_first_set_clear_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap find-first set/clear unit
// Allocation bitmap held in a word memory, with set, clear, find-first and
// fill operations run one word per cycle by a small sequencer.
// ---------------------------------------------------------------------------
//  Channel  Dir  Width  Contents (lowest bit first)
//  s_*      in   16     func[2:0], bit_number[12:3]
//  m_*      out  16     found[0], found_index[10:1], all_clear[11], all_set[12]
//
//  Searches scan from the lowest word up until a hit or the last word.
//  Set and clear step through fetch, read-modify-write, result and idle; the
//  word index is the upper bits of bit_number, as WORD_BITS is a power of two.
//  Fill and clear-all write one word per cycle, then go to result.
//  After reset a clearing pass runs before s_tready rises.
//  A finished result waits in the output register while m_tready is low;
//  the next transaction may be accepted meanwhile.
// ---------------------------------------------------------------------------
module bitmap_find_first_set_clear_unit
  import bmfs_pkg::*;
#(
  parameter int BIT_COUNT = BIT_COUNT_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // func[2:0], bit_number[12:3]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [M_TDATA_W-1:0] m_tdata   // found, found_index, all_clear, all_set
);

  localparam int NWORDS = BIT_COUNT / WORD_BITS;
  localparam int TOTAL  = NWORDS * WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW     = $clog2(NWORDS + 1);
  localparam int BW     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int IDXW   = $clog2(TOTAL + 1);

  typedef enum logic [5:0] {
    S_SWEEP  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_FETCH  = 6'b000100,
    S_RMW    = 6'b001000,
    S_SCAN   = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t                 state;
  logic [AW-1:0]          wc;
  logic [BITNUM_W-1:0]    rem;
  logic [IDXW-1:0]        base;
  logic                   sweep_ones;
  logic                   sweep_init;
  logic                   find_clear;
  logic                   op_set;
  logic                   res_found;
  logic [IDXW-1:0]        res_idx;
  logic [CW-1:0]          zero_count;
  logic [CW-1:0]          full_count;

  func_t                  in_func;
  logic [BITNUM_W-1:0]    in_bitnum;
  logic                   last_word;
  logic                   out_load;
  logic [IDXW+INDEX_W-1:0] idx_wide;

  logic                   mem_we;
  logic [AW-1:0]          mem_raddr;
  logic [WORD_BITS-1:0]   mem_wdata;
  logic [WORD_BITS-1:0]   mem_rdata;
  logic [BW-1:0]          hit_pos;
  logic [WORD_BITS-1:0]   new_word;
  word_stat_t             stat;

  assign in_func   = func_t'(s_tdata[FUNC_W-1:0]);
  assign in_bitnum = s_tdata[FUNC_W +: BITNUM_W];
  assign last_word = (wc == AW'(NWORDS - 1));
  assign idx_wide  = {{INDEX_W{1'b0}}, res_idx};
  assign s_tready  = (state == S_IDLE);
  assign out_load  = (state == S_RESULT) && (!m_tvalid || m_tready);

  always_comb begin
    case (state)
      S_SCAN:  mem_raddr = wc + AW'(1);
      S_FETCH: mem_raddr = wc;
      default: mem_raddr = '0;
    endcase
  end

  assign mem_we    = (state == S_SWEEP) || (state == S_RMW);
  assign mem_wdata = (state == S_SWEEP) ? {WORD_BITS{sweep_ones}} : new_word;

  bmfs_mem #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wc),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmfs_word_unit #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW)
  ) u_word (
    .word       (mem_rdata),
    .find_clear (find_clear),
    .op_set     (op_set),
    .bit_pos    (rem[BW-1:0]),
    .hit_pos    (hit_pos),
    .new_word   (new_word),
    .stat       (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      wc         <= '0;
      sweep_ones <= 1'b0;
      sweep_init <= 1'b1;
      zero_count <= CW'(NWORDS);
      full_count <= '0;
      m_tvalid   <= 1'b0;
      res_found  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          wc <= wc + AW'(1);
          if (last_word) begin
            zero_count <= sweep_ones ? '0 : CW'(NWORDS);
            full_count <= sweep_ones ? CW'(NWORDS) : '0;
            sweep_init <= 1'b0;
            state      <= sweep_init ? S_IDLE : S_RESULT;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            res_found <= 1'b0;
            res_idx   <= '0;
            base      <= '0;
            case (in_func)
              FN_SET_BIT, FN_CLEAR_BIT: begin
                op_set <= (in_func == FN_SET_BIT);
                rem    <= in_bitnum;
                wc     <= AW'(in_bitnum >> BW);
                // Bit numbers beyond the bitmap leave it unchanged.
                state  <= (32'(in_bitnum) < 32'(TOTAL)) ? S_FETCH : S_RESULT;
              end
              FN_FIND_SET, FN_FIND_CLEAR: begin
                find_clear <= (in_func == FN_FIND_CLEAR);
                wc         <= '0;
                state      <= S_SCAN;
              end
              FN_FILL_ONES, FN_CLEAR_ALL: begin
                sweep_ones <= (in_func == FN_FILL_ONES);
                wc         <= '0;
                state      <= S_SWEEP;
              end
              default: state <= S_RESULT;
            endcase
          end
        end
        S_FETCH: begin
          state <= S_RMW;
        end
        S_RMW: begin
          if (stat.old_zero && !stat.new_zero) begin
            zero_count <= zero_count - CW'(1);
          end else if (!stat.old_zero && stat.new_zero) begin
            zero_count <= zero_count + CW'(1);
          end
          if (stat.old_full && !stat.new_full) begin
            full_count <= full_count - CW'(1);
          end else if (!stat.old_full && stat.new_full) begin
            full_count <= full_count + CW'(1);
          end
          state <= S_RESULT;
        end
        S_SCAN: begin
          if (stat.hit) begin
            res_found <= 1'b1;
            res_idx   <= base + IDXW'(hit_pos);
            state     <= S_RESULT;
          end else if (last_word) begin
            state <= S_RESULT;
          end else begin
            wc   <= wc + AW'(1);
            base <= base + IDXW'(WORD_BITS);
          end
        end
        S_RESULT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(M_TDATA_W - INDEX_W - 3){1'b0}},
                  (full_count == CW'(NWORDS)),
                  (zero_count == CW'(NWORDS)),
                  res_found ? idx_wide[INDEX_W-1:0] : INDEX_W'(0),
                  res_found};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bmfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Bitmap unit port checker
// Watches the stream ports of the bitmap unit for consistent results.
// ---------------------------------------------------------------------------
module bmfs_checker
  import bmfs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TDATA_W-1:0] s_tdata,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata
);

  // A result not taken must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The bitmap cannot be empty and full at once.
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[11] && m_tdata[12]))
    else $error("all_clear and all_set both high");

  // A miss reports index zero.
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[10:1] == 10'd0)
    else $error("non-zero index without a hit");

  // Ready stays low in the cycle after a transaction is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready again straight after a transaction");

endmodule

bind bitmap_find_first_set_clear_unit bmfs_checker u_bmfs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: sim/bitmap_find_first_set_clear_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bitmap find-first set/clear unit testbench
// Drives set, clear, search, fill, clear-all and unused-code transactions into
// the unit and checks every result against a cycle-free model of the allocation bitmap.
// ---------------------------------------------------------------------------
module bitmap_find_first_set_clear_unit_tb;
  import bmfs_pkg::*;

  localparam int BITS        = BIT_COUNT_DEF;
  localparam int WBITS       = WORD_BITS_DEF;
  localparam int NWORDS      = BITS / WBITS;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int TAIL_CYCLES = 4 * NWORDS;

  // The two codes the unit leaves unused; they must change nothing.
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0]   fn;
    logic [BITNUM_W-1:0] bitn;
  } bitmap_op_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               all_clear;
    logic               all_set;
  } bitmap_status_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  bitmap_op_t     pending_ops[$];
  bitmap_status_t expected_status[$];
  logic [WBITS-1:0] bitmap_copy [NWORDS];

  logic s_taken = 1'b0;
  int   send_idle_pct = 25;
  int   recv_idle_pct = 75;
  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_checked = 0;
  int   n_errors = 0;
  int   n_hits = 0;
  int   n_full = 0;
  int   n_empty = 0;
  int   cycle_count = 0;
  int   ops_by_func [8];

  bitmap_find_first_set_clear_unit #(
    .BIT_COUNT(BITS),
    .WORD_BITS(WBITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < 40)
      $display("%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  // Applies one operation to the local bitmap copy and returns its status.
  function automatic bitmap_status_t apply_bitmap_op(input logic [FUNC_W-1:0] fn,
                                                     input logic [BITNUM_W-1:0] bitn);
    bitmap_status_t st;
    logic want;
    int w;
    int b;
    st = '0;
    want = (fn == FN_FIND_SET);
    case (fn)
      FN_SET_BIT: begin
        if (int'(bitn) < NWORDS * WBITS) bitmap_copy[bitn / WBITS][bitn % WBITS] = 1'b1;
      end
      FN_CLEAR_BIT: begin
        if (int'(bitn) < NWORDS * WBITS) bitmap_copy[bitn / WBITS][bitn % WBITS] = 1'b0;
      end
      FN_FIND_SET, FN_FIND_CLEAR: begin
        for (w = 0; w < NWORDS; w++)
          for (b = 0; b < WBITS; b++)
            if (!st.found && bitmap_copy[w][b] == want) begin
              st.found = 1'b1;
              st.found_index = INDEX_W'(w * WBITS + b);
            end
      end
      FN_FILL_ONES: begin
        for (w = 0; w < NWORDS; w++) bitmap_copy[w] = '1;
      end
      FN_CLEAR_ALL: begin
        for (w = 0; w < NWORDS; w++) bitmap_copy[w] = '0;
      end
      default: ;
    endcase
    st.all_clear = 1'b1;
    st.all_set = 1'b1;
    for (w = 0; w < NWORDS; w++) begin
      if (bitmap_copy[w] != '0) st.all_clear = 1'b0;
      if (bitmap_copy[w] != '1) st.all_set = 1'b0;
    end
    return st;
  endfunction

  // Sender: holds an offered transaction until taken, otherwise may idle.
  always @(negedge clk) begin
    bitmap_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_taken) begin
      s_tvalid <= 1'b1;
    end else if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      op = pending_ops.pop_front();
      s_tdata <= S_TDATA_W'({op.bitn, op.fn});
      s_tvalid <= 1'b1;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: the result is checked before the new expectation is queued, as
  // a result leaving on this edge always belongs to an earlier transaction.
  always @(posedge clk) begin
    bitmap_status_t want;
    bitmap_status_t got;
    s_taken <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.found = m_tdata[0];
        got.found_index = m_tdata[10:1];
        got.all_clear = m_tdata[11];
        got.all_set = m_tdata[12];
        if (expected_status.size() == 0) begin
          report_mismatch("result with nothing outstanding, m_tdata", m_tdata, 0);
        end else begin
          want = expected_status.pop_front();
          n_checked++;
          if (got.found != want.found)
            report_mismatch("found", got.found, want.found);
          if (got.found_index != want.found_index)
            report_mismatch("found_index", got.found_index, want.found_index);
          if (got.all_clear != want.all_clear)
            report_mismatch("all_clear", got.all_clear, want.all_clear);
          if (got.all_set != want.all_set)
            report_mismatch("all_set", got.all_set, want.all_set);
          if (want.found) n_hits++;
          if (want.all_set) n_full++;
          if (want.all_clear) n_empty++;
        end
      end
      if (s_tvalid && s_tready) begin
        expected_status.push_back(apply_bitmap_op(s_tdata[2:0], s_tdata[12:3]));
        ops_by_func[s_tdata[2:0]]++;
        n_accepted++;
      end
    end
  end

  task automatic queue_op(input logic [FUNC_W-1:0] fn, input logic [BITNUM_W-1:0] bitn);
    bitmap_op_t op;
    op.fn = fn;
    op.bitn = bitn;
    pending_ops.push_back(op);
    n_queued++;
  endtask

  // Word edges are favoured since they sit on the boundaries of the scan.
  function automatic logic [BITNUM_W-1:0] pick_bit();
    int w;
    w = $urandom_range(0, NWORDS - 1);
    case ($urandom_range(0, 3))
      0:       return BITNUM_W'(w * WBITS);
      1:       return BITNUM_W'(w * WBITS + WBITS - 1);
      default: return BITNUM_W'($urandom_range(0, BITS - 1));
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return FN_SET_BIT;
    if (r < 60) return FN_CLEAR_BIT;
    if (r < 75) return FN_FIND_SET;
    if (r < 90) return FN_FIND_CLEAR;
    if (r < 93) return FN_FILL_ONES;
    if (r < 96) return FN_CLEAR_ALL;
    if (r < 98) return FN_SPARE_6;
    return FN_SPARE_7;
  endfunction

  // Punches a few holes in a full bitmap, searches, then fills them again.
  task automatic queue_near_full();
    logic [BITNUM_W-1:0] holes [4];
    int k;
    int i;
    k = $urandom_range(1, 4);
    queue_op(FN_FILL_ONES, pick_bit());
    queue_op(FN_FIND_CLEAR, pick_bit());
    for (i = 0; i < k; i++) begin
      holes[i] = pick_bit();
      queue_op(FN_CLEAR_BIT, holes[i]);
    end
    queue_op(FN_FIND_CLEAR, pick_bit());
    queue_op(FN_FIND_SET, pick_bit());
    for (i = 0; i < k; i++) begin
      queue_op(FN_SET_BIT, holes[i]);
      queue_op(FN_FIND_CLEAR, pick_bit());
    end
  endtask

  // Sets a few bits in an empty bitmap and removes them one at a time.
  task automatic queue_sparse();
    logic [BITNUM_W-1:0] marks [4];
    int k;
    int i;
    k = $urandom_range(1, 4);
    queue_op(FN_CLEAR_ALL, pick_bit());
    for (i = 0; i < k; i++) begin
      marks[i] = pick_bit();
      queue_op(FN_SET_BIT, marks[i]);
    end
    queue_op(FN_FIND_SET, pick_bit());
    queue_op(FN_FIND_CLEAR, pick_bit());
    for (i = 0; i < k; i++) begin
      queue_op(FN_CLEAR_BIT, marks[i]);
      queue_op(FN_FIND_SET, pick_bit());
    end
  endtask

  task automatic queue_random(input int count);
    int target;
    int r;
    target = n_queued + count;
    while (n_queued < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        queue_op(pick_func(), pick_bit());
      end else if (r < 75) begin
        queue_near_full();
      end else if (r < 95) begin
        queue_sparse();
      end else begin
        repeat (3) queue_op(FUNC_W'($urandom_range(0, 7)), BITNUM_W'($urandom()));
      end
    end
  endtask

  // The test holds off here until every queued transaction has its result.
  task automatic drain();
    do @(posedge clk); while (pending_ops.size() != 0 || s_tvalid);
    do @(negedge clk); while (expected_status.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    queue_op(FN_FIND_SET, 10'd0);
    queue_op(FN_FIND_CLEAR, 10'd1023);
    queue_op(FN_SET_BIT, 10'd0);
    queue_op(FN_SET_BIT, 10'd1023);
    queue_op(FN_FIND_SET, 10'd0);
    queue_op(FN_CLEAR_BIT, 10'd0);
    queue_op(FN_FIND_SET, 10'd0);
    queue_op(FN_FIND_CLEAR, 10'd0);
    queue_op(FN_FILL_ONES, 10'd0);
    queue_op(FN_FIND_CLEAR, 10'd0);
    queue_op(FN_FIND_SET, 10'd1023);
    queue_op(FN_CLEAR_BIT, 10'd1023);
    queue_op(FN_FIND_CLEAR, 10'd0);
    queue_op(FN_SET_BIT, 10'd1023);
    queue_op(FN_CLEAR_BIT, 10'd511);
    queue_op(FN_FIND_CLEAR, 10'd0);
    queue_op(FN_SPARE_6, 10'd1023);
    queue_op(FN_SPARE_7, 10'd0);
    queue_op(FN_CLEAR_ALL, 10'd0);
    queue_op(FN_FIND_SET, 10'd1023);
    queue_op(FN_SET_BIT, 10'd512);
    queue_op(FN_SPARE_7, 10'd512);
    queue_op(FN_CLEAR_BIT, 10'd512);
    queue_op(FN_FIND_SET, 10'd0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    queue_random(310);
    drain();
    send_idle_pct = 75;
    recv_idle_pct = 25;
    queue_random(330);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(330);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_status.size() != 0)
      report_mismatch("results never delivered", expected_status.size(), 0);
    $display("Checked %0d of %0d transactions: %0d set, %0d clear, %0d find-set, %0d find-clear",
             n_checked, n_accepted, ops_by_func[FN_SET_BIT], ops_by_func[FN_CLEAR_BIT],
             ops_by_func[FN_FIND_SET], ops_by_func[FN_FIND_CLEAR]);
    $display("%0d fills, %0d clear-alls, %0d unused codes; %0d hits, %0d full, %0d empty",
             ops_by_func[FN_FILL_ONES], ops_by_func[FN_CLEAR_ALL],
             ops_by_func[FN_SPARE_6] + ops_by_func[FN_SPARE_7], n_hits, n_full, n_empty);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int w;
    for (w = 0; w < NWORDS; w++) bitmap_copy[w] = '0;
    for (w = 0; w < 8; w++) ops_by_func[w] = 0;
  end

endmodule

FILE: bitmap_find_first_set_clear_unit.f
rtl/core/bmfs_pkg.sv
rtl/core/bmfs_mem.sv
rtl/core/bmfs_word_unit.sv
rtl/core/bitmap_find_first_set_clear_unit.sv
rtl/core/bmfs_checker.sv
sim/bitmap_find_first_set_clear_unit_tb.sv
